### rtl/dht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_pkg: shared types and codes for the deadline heap timer
// Command and result words, engine states, result and status codes.
// ----------------------------------------------------------------------------
package dht_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_ACK,
        ST_TK_RD,
        ST_TK_CMP,
        ST_TK_EXP,
        ST_TK_MOVE,
        ST_TK_WAIT,
        ST_TK_EMPTY
    } eng_state_t;

    localparam logic       KIND_SET     = 1'b0;
    localparam logic       KIND_TICK    = 1'b1;

    localparam logic [1:0] RK_EXPIRED   = 2'd0;
    localparam logic [1:0] RK_WAIT      = 2'd1;
    localparam logic [1:0] RK_SET       = 2'd2;

    localparam logic [1:0] SS_ADDED     = 2'd0;
    localparam logic [1:0] SS_REARMED   = 2'd1;
    localparam logic [1:0] SS_REJECTED  = 2'd2;

    localparam logic [31:0] WAIT_NONE   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [7:0]  id;
        logic [31:0] deadline;
        logic [31:0] now;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  rkind;
        logic [7:0]  id;
        logic [31:0] wait_ms;
        logic [1:0]  status;
        logic        last;
    } res_t;

    // a is strictly before b in wrapping time
    function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

endpackage

### rtl/dht_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_front: command intake
// Takes input words, forms the absolute deadline and queues up to two commands.
// ----------------------------------------------------------------------------
module dht_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           kind,
    input  logic [7:0]     timer_id,
    input  logic [30:0]    timeout_ms,
    input  logic [31:0]    now_ms,
    output dht_pkg::cmd_t  head,
    output logic           head_valid,
    input  logic           pop
);
    import dht_pkg::*;

    cmd_t       q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       cmd_in;

    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        cmd_in.kind     = kind;
        cmd_in.id       = timer_id;
        cmd_in.deadline = now_ms + {1'b0, timeout_ms};
        cmd_in.now      = now_ms;
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ (pop && head_valid);
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop && head_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### rtl/dht_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_engine: heap sequencer
// Runs inserts, re-arms and tick expiries over the heap and id-map memories.
// ----------------------------------------------------------------------------
module dht_engine #(
    parameter int CAPACITY = 32,
    parameter int ID_BITS  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  dht_pkg::cmd_t  head,
    input  logic           head_valid,
    output logic           pop,
    output dht_pkg::res_t  res,
    output logic           push,
    input  logic           room
);
    import dht_pkg::*;

    localparam int PW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = PW + 2;
    localparam int EW  = ID_BITS + 32;
    localparam int NID = 2 ** ID_BITS;

    logic [EW-1:0]      heap_mem [CAPACITY];
    logic [CW-1:0]      map_mem  [NID];

    eng_state_t         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [ID_BITS-1:0] cur_id_reg, cur_id_next;
    logic [31:0]        cur_dl_reg, cur_dl_next;
    logic               moved_reg, moved_next;
    logic [1:0]         status_reg, status_next;
    logic               kind_reg, kind_next;
    logic [31:0]        now_reg, now_next;
    logic [EW-1:0]      lch_reg, lch_next;
    logic               rv_reg, rv_next;
    logic [EW-1:0]      root_reg, root_next;
    logic [ID_BITS-1:0] clr_reg, clr_next;

    logic               hp_re, hp_we;
    logic [PW-1:0]      hp_raddr, hp_waddr;
    logic [EW-1:0]      hp_wdata, hp_rdata_reg;
    logic               mp_re, mp_we;
    logic [ID_BITS-1:0] mp_raddr, mp_waddr;
    logic [CW-1:0]      mp_wdata, mp_rdata_reg;

    logic [XW-1:0]      lidx, ridx;
    logic [PW-1:0]      pos_m1, parent;
    logic [CW-1:0]      count_m1, pos_p1;
    logic [ID_BITS-1:0] rd_id;
    logic [31:0]        rd_dl, lch_dl, root_dl, wait_d;
    logic               take_l, take_r;
    logic               emit;
    eng_state_t         done_state;

    assign lidx     = {1'b0, pos_reg, 1'b1};
    assign ridx     = {1'b0, pos_reg, 1'b0} + XW'(2);
    assign pos_m1   = pos_reg - 1'b1;
    assign parent   = pos_m1 >> 1;
    assign count_m1 = count_reg - 1'b1;
    assign pos_p1   = CW'(pos_reg) + 1'b1;
    assign rd_id    = hp_rdata_reg[EW-1:32];
    assign rd_dl    = hp_rdata_reg[31:0];
    assign lch_dl   = lch_reg[31:0];
    assign root_dl  = root_reg[31:0];
    assign wait_d   = root_dl - now_reg;

    // sift-down pick: moves only on strictly earlier
    assign take_l = earlier(lch_dl, cur_dl_reg);
    assign take_r = rv_reg && earlier(rd_dl, take_l ? lch_dl : cur_dl_reg);

    assign done_state = (kind_reg == KIND_SET) ? ST_ACK : ST_TK_RD;
    assign push       = emit && room;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        cur_id_next = cur_id_reg;
        cur_dl_next = cur_dl_reg;
        moved_next  = moved_reg;
        status_next = status_reg;
        kind_next   = kind_reg;
        now_next    = now_reg;
        lch_next    = lch_reg;
        rv_next     = rv_reg;
        root_next   = root_reg;
        clr_next    = clr_reg;
        pop         = 1'b0;
        emit        = 1'b0;
        res         = '0;
        hp_re       = 1'b0;
        hp_raddr    = '0;
        hp_we       = 1'b0;
        hp_waddr    = pos_reg;
        hp_wdata    = {cur_id_reg, cur_dl_reg};
        mp_re       = 1'b0;
        mp_raddr    = ID_BITS'(head.id);
        mp_we       = 1'b0;
        mp_waddr    = cur_id_reg;
        mp_wdata    = pos_p1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mp_we    = 1'b1;
                mp_waddr = clr_reg;
                mp_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {ID_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop         = 1'b1;
                    kind_next   = head.kind;
                    cur_id_next = ID_BITS'(head.id);
                    cur_dl_next = head.deadline;
                    now_next    = head.now;
                    moved_next  = 1'b0;
                    if (head.kind == KIND_SET)
                    begin
                        mp_re      = 1'b1;
                        state_next = ST_SET;
                    end
                    else
                    begin
                        state_next = ST_TK_RD;
                    end
                end
            end
            ST_SET:
            begin
                if (mp_rdata_reg != '0 && (mp_rdata_reg - 1'b1) < count_reg)
                begin
                    pos_next    = PW'(mp_rdata_reg - 1'b1);
                    status_next = SS_REARMED;
                    state_next  = ST_UP_RD;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    status_next = SS_REJECTED;
                    state_next  = ST_ACK;
                end
                else
                begin
                    pos_next    = PW'(count_reg);
                    count_next  = count_reg + 1'b1;
                    status_next = SS_ADDED;
                    state_next  = ST_UP_RD;
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    if (moved_reg)
                    begin
                        hp_we      = 1'b1;
                        mp_we      = 1'b1;
                        state_next = done_state;
                    end
                    else
                    begin
                        state_next = ST_DN_RDL;
                    end
                end
                else
                begin
                    hp_re      = 1'b1;
                    hp_raddr   = parent;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (earlier(cur_dl_reg, rd_dl))
                begin
                    // parent drops into the hole
                    hp_we      = 1'b1;
                    hp_wdata   = hp_rdata_reg;
                    mp_we      = 1'b1;
                    mp_waddr   = rd_id;
                    pos_next   = parent;
                    moved_next = 1'b1;
                    state_next = ST_UP_RD;
                end
                else if (moved_reg)
                begin
                    hp_we      = 1'b1;
                    mp_we      = 1'b1;
                    state_next = done_state;
                end
                else
                begin
                    state_next = ST_DN_RDL;
                end
            end
            ST_DN_RDL:
            begin
                if (lidx >= XW'(count_reg))
                begin
                    hp_we      = 1'b1;
                    mp_we      = 1'b1;
                    state_next = done_state;
                end
                else
                begin
                    hp_re      = 1'b1;
                    hp_raddr   = PW'(lidx);
                    state_next = ST_DN_RDR;
                end
            end
            ST_DN_RDR:
            begin
                lch_next   = hp_rdata_reg;
                rv_next    = (ridx < XW'(count_reg));
                hp_re      = (ridx < XW'(count_reg));
                hp_raddr   = PW'(ridx);
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                hp_we = 1'b1;
                mp_we = 1'b1;
                if (take_r)
                begin
                    hp_wdata   = hp_rdata_reg;
                    mp_waddr   = rd_id;
                    pos_next   = PW'(ridx);
                    state_next = ST_DN_RDL;
                end
                else if (take_l)
                begin
                    hp_wdata   = lch_reg;
                    mp_waddr   = lch_reg[EW-1:32];
                    pos_next   = PW'(lidx);
                    state_next = ST_DN_RDL;
                end
                else
                begin
                    state_next = done_state;
                end
            end
            ST_ACK:
            begin
                emit        = 1'b1;
                res.rkind   = RK_SET;
                res.id      = 8'(cur_id_reg);
                res.status  = status_reg;
                res.last    = 1'b1;
                if (room)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TK_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_TK_EMPTY;
                end
                else
                begin
                    hp_re      = 1'b1;
                    hp_raddr   = '0;
                    state_next = ST_TK_CMP;
                end
            end
            ST_TK_CMP:
            begin
                root_next  = hp_rdata_reg;
                state_next = earlier(now_reg, rd_dl) ? ST_TK_WAIT : ST_TK_EXP;
            end
            ST_TK_EXP:
            begin
                emit      = 1'b1;
                res.rkind = RK_EXPIRED;
                res.id    = 8'(root_reg[EW-1:32]);
                if (room)
                begin
                    mp_we      = 1'b1;
                    mp_waddr   = root_reg[EW-1:32];
                    mp_wdata   = '0;
                    count_next = count_m1;
                    if (count_m1 != '0)
                    begin
                        hp_re      = 1'b1;
                        hp_raddr   = PW'(count_m1);
                        state_next = ST_TK_MOVE;
                    end
                    else
                    begin
                        state_next = ST_TK_RD;
                    end
                end
            end
            ST_TK_MOVE:
            begin
                // last entry refills the root and sinks
                cur_id_next = rd_id;
                cur_dl_next = rd_dl;
                pos_next    = '0;
                moved_next  = 1'b0;
                state_next  = ST_DN_RDL;
            end
            ST_TK_WAIT:
            begin
                emit        = 1'b1;
                res.rkind   = RK_WAIT;
                res.wait_ms = wait_d[31] ? 32'd0 : wait_d;
                res.last    = 1'b1;
                if (room)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TK_EMPTY:
            begin
                emit        = 1'b1;
                res.rkind   = RK_WAIT;
                res.wait_ms = WAIT_NONE;
                res.last    = 1'b1;
                if (room)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        cur_id_reg <= cur_id_next;
        cur_dl_reg <= cur_dl_next;
        moved_reg  <= moved_next;
        status_reg <= status_next;
        kind_reg   <= kind_next;
        now_reg    <= now_next;
        lch_reg    <= lch_next;
        rv_reg     <= rv_next;
        root_reg   <= root_next;
    end

    always_ff @(posedge clk)
    begin
        if (hp_we)
        begin
            heap_mem[hp_waddr] <= hp_wdata;
        end
        if (hp_re)
        begin
            hp_rdata_reg <= heap_mem[hp_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mp_we)
        begin
            map_mem[mp_waddr] <= mp_wdata;
        end
        if (mp_re)
        begin
            mp_rdata_reg <= map_mem[mp_raddr];
        end
    end

endmodule

### rtl/dht_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_out: result buffer
// Two-word queue between the engine and the result channel.
// ----------------------------------------------------------------------------
module dht_out (
    input  logic           clk,
    input  logic           rst_n,
    input  dht_pkg::res_t  res,
    input  logic           push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     result_kind,
    output logic [7:0]     expired_id,
    output logic [31:0]    wait_ms,
    output logic [1:0]     set_status,
    output logic           last
);
    import dht_pkg::*;

    res_t       q_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;
    res_t       head;

    assign room      = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign head      = q_reg[rd_ptr_reg];

    assign result_kind = head.rkind;
    assign expired_id  = head.id;
    assign wait_ms     = head.wait_ms;
    assign set_status  = head.status;
    assign last        = head.last;

    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_reg ^ pop;
            wr_ptr_reg <= wr_ptr_reg ^ push;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

### rtl/deadline_heap_timer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_heap_timer_top: min-heap timer queue
//
//   channel | handshake            | word
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_ready  | kind, timer_id, timeout_ms, now_ms
//   result  | out_valid / out_ready| result_kind, expired_id, wait_ms,
//           |                      | set_status, last
//
// A set climbs the entry toward the root or sinks it; a tick expires each due
// timer, refilling the root with the last entry and sinking it. Levels climbed
// or sunk are at most log2(CAPACITY).
// After reset a clearing pass over all 2**ID_BITS entries empties the id map;
// input words queue (two deep) meanwhile. A stalled result side holds the
// engine once the two-word result buffer is full.
// ----------------------------------------------------------------------------
module deadline_heap_timer_top #(
    parameter int CAPACITY = 32,
    parameter int ID_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  timer_id,
    input  logic [30:0] timeout_ms,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  expired_id,
    output logic [31:0] wait_ms,
    output logic [1:0]  set_status,
    output logic        last
);
    import dht_pkg::*;

    cmd_t head;
    logic head_valid, pop;
    res_t res;
    logic push, room;

    dht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .timer_id   (timer_id),
        .timeout_ms (timeout_ms),
        .now_ms     (now_ms),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    dht_engine #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .res        (res),
        .push       (push),
        .room       (room)
    );

    dht_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .push        (push),
        .room        (room),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .expired_id  (expired_id),
        .wait_ms     (wait_ms),
        .set_status  (set_status),
        .last        (last)
    );

    a_set_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == RK_SET) |-> last)
        else $error("set acknowledge without last");

    a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == RK_EXPIRED) |-> (!last && wait_ms == 32'd0))
        else $error("expired word with last or wait");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("result buffer overflow");

endmodule
